// ===== src/u2d_pkg.sv =====
// shared types and constants of the utf-8 to ucs-2 decoder
`default_nettype none
package u2d_pkg;

   localparam logic [15:0] ERROR_CHAR_RESET = 16'h003F;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [4:0] {
      PK_NONE    = 5'b00001,
      PK_TWO     = 5'b00010,
      PK_THREE_A = 5'b00100,
      PK_THREE_B = 5'b01000,
      PK_LONG    = 5'b10000
   } pending_kind_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_error;
      logic        last_of_run;
   } result_type;

   // up to two results caused by one input word
   typedef struct packed {
      result_type first;
      result_type second;
      logic       two;
   } job_type;

endpackage
`default_nettype wire

// ===== src/u2d_ifs.sv =====
// channel interfaces of the decoder
`default_nettype none
interface u2d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;
   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u2d_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        is_error;
   logic        last_of_run;
   modport source (output valid, output code_unit, output is_error, output last_of_run,
                   input ready);
   modport sink (input valid, input code_unit, input is_error, input last_of_run,
                 output ready);
endinterface

interface u2d_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] error_char;
   modport source (output valid, output error_char, input ready);
   modport sink (input valid, input error_char, output ready);
endinterface
`default_nettype wire

// ===== src/utf8_to_ucs2_decoder_unit.sv =====
// top level of the utf-8 to ucs-2 decoder
//
//   channel  dir  payload                                   word moved when
//   req_if   in   in_byte[8], end_of_string[1]              valid && ready
//   rsp_if   out  code_unit[16], is_error[1], last_of_run[1] valid && ready
//   csr_if   in   error_char[16]                            valid && ready
//
// one input word per cycle while the job queue is not full; a word that yields
// two results holds the back end for both, absorbed by the job queue between
// front and back. a result passes that queue, then the output register.
// reset restores error_char to 003f and clears the sequence state and queue.
// req_if stalls only when the job queue is full; csr_if never stalls.
`default_nettype none
module utf8_to_ucs2_decoder_unit #(
   parameter int unsigned QUEUE_DEPTH = u2d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   u2d_req_if.sink   req_if,
   u2d_rsp_if.source rsp_if,
   u2d_csr_if.sink   csr_if
);

   logic             queue_full, push, pop, head_valid;
   u2d_pkg::job_type push_job, head_job;

   assign csr_if.ready = 1'b1;

   u2d_front front_i (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_byte    (req_if.in_byte),
      .in_eos     (req_if.end_of_string),
      .queue_full (queue_full),
      .csr_valid  (csr_if.valid),
      .csr_data   (csr_if.error_char),
      .in_ready   (req_if.ready),
      .push       (push),
      .push_job   (push_job)
   );

   u2d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) queue_i (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u2d_back back_i (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp        (rsp_if)
   );

endmodule
`default_nettype wire

// ===== src/u2d_front.sv =====
// byte classification, sequence state and result selection
`default_nettype none
module u2d_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire logic [7:0]      in_byte,
   input  wire logic            in_eos,
   input  wire logic            queue_full,
   input  wire logic            csr_valid,
   input  wire logic [15:0]     csr_data,
   output logic                 in_ready,
   output logic                 push,
   output u2d_pkg::job_type     push_job
);

   u2d_pkg::pending_kind_type kind_ff, kind_in;
   logic [9:0]  partial_ff, partial_in;
   logic [1:0]  long_count_ff, long_count_in;
   logic [15:0] error_char_ff, error_char_in;

   logic        accept, cont, consumed, ends;
   logic        a_hit, m_hit, f_hit;
   logic        a_ok, m_ok, f_ok;
   logic [15:0] m_cu;
   logic        m_err;
   u2d_pkg::result_type a_res, m_res, f_res;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign cont     = (in_byte[7:6] == 2'b10);
   assign ends     = in_eos || (in_byte == 8'h00);
   assign error_char_in = csr_valid ? csr_data : error_char_ff;

   always_comb begin
      kind_in       = kind_ff;
      partial_in    = partial_ff;
      long_count_in = long_count_ff;
      a_hit    = 1'b0;
      m_hit    = 1'b0;
      f_hit    = 1'b0;
      m_cu     = 16'h0000;
      m_err    = 1'b0;
      consumed = 1'b0;
      if (kind_ff != u2d_pkg::PK_NONE) begin
         if (!cont) begin
            a_hit         = 1'b1;
            kind_in       = u2d_pkg::PK_NONE;
            partial_in    = 10'd0;
            long_count_in = 2'd0;
         end else begin
            consumed = 1'b1;
            unique case (kind_ff)
               u2d_pkg::PK_TWO, u2d_pkg::PK_THREE_B: begin
                  m_hit         = 1'b1;
                  m_cu          = {partial_ff, in_byte[5:0]};
                  kind_in       = u2d_pkg::PK_NONE;
                  partial_in    = 10'd0;
                  long_count_in = 2'd0;
               end
               u2d_pkg::PK_THREE_A: begin
                  partial_in = {partial_ff[3:0], in_byte[5:0]};
                  kind_in    = u2d_pkg::PK_THREE_B;
               end
               u2d_pkg::PK_LONG: begin
                  if (long_count_ff >= 2'd2) begin
                     m_hit         = 1'b1;
                     m_cu          = error_char_ff;
                     m_err         = 1'b1;
                     kind_in       = u2d_pkg::PK_NONE;
                     partial_in    = 10'd0;
                     long_count_in = 2'd0;
                  end else begin
                     long_count_in = long_count_ff + 2'd1;
                  end
               end
               default: begin
                  kind_in       = u2d_pkg::PK_NONE;
                  partial_in    = 10'd0;
                  long_count_in = 2'd0;
               end
            endcase
         end
      end
      if (!consumed) begin
         priority if (in_byte == 8'h00) begin
            kind_in       = u2d_pkg::PK_NONE;
            partial_in    = 10'd0;
            long_count_in = 2'd0;
         end else if (!in_byte[7]) begin
            m_hit = 1'b1;
            m_cu  = {8'h00, in_byte};
         end else if (in_byte[7:5] == 3'b110) begin
            kind_in       = u2d_pkg::PK_TWO;
            partial_in    = {5'd0, in_byte[4:0]};
            long_count_in = 2'd0;
         end else if (in_byte[7:4] == 4'b1110) begin
            kind_in       = u2d_pkg::PK_THREE_A;
            partial_in    = {6'd0, in_byte[3:0]};
            long_count_in = 2'd0;
         end else if (in_byte[7:3] == 5'b11110) begin
            kind_in       = u2d_pkg::PK_LONG;
            partial_in    = 10'd0;
            long_count_in = 2'd0;
         end else begin
            m_hit = 1'b1;
            m_cu  = error_char_ff;
            m_err = 1'b1;
         end
      end
      if (ends) begin
         f_hit         = (kind_in != u2d_pkg::PK_NONE);
         kind_in       = u2d_pkg::PK_NONE;
         partial_in    = 10'd0;
         long_count_in = 2'd0;
      end
   end

   // zero code units are never delivered
   assign a_ok = a_hit && (error_char_ff != 16'h0000);
   assign m_ok = m_hit && (m_cu != 16'h0000);
   assign f_ok = f_hit && (error_char_ff != 16'h0000);

   assign a_res = '{code_unit: error_char_ff, is_error: 1'b1, last_of_run: 1'b0};
   assign m_res = '{code_unit: m_cu, is_error: m_err, last_of_run: 1'b0};
   assign f_res = '{code_unit: error_char_ff, is_error: 1'b1, last_of_run: 1'b1};

   always_comb begin
      push_job     = '0;
      push_job.two = (a_ok && m_ok) || (a_ok && f_ok) || (m_ok && f_ok);
      priority if (a_ok) begin
         push_job.first  = a_res;
         push_job.second = m_ok ? m_res : f_res;
      end else if (m_ok) begin
         push_job.first  = m_res;
         push_job.second = f_res;
      end else begin
         push_job.first  = f_res;
         push_job.second = f_res;
      end
      push_job.first.last_of_run  = !push_job.two;
      push_job.second.last_of_run = 1'b1;
   end

   assign push = accept && (a_ok || m_ok || f_ok);

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= u2d_pkg::PK_NONE;
         partial_ff    <= 10'd0;
         long_count_ff <= 2'd0;
         error_char_ff <= u2d_pkg::ERROR_CHAR_RESET;
      end else begin
         error_char_ff <= error_char_in;
         if (accept) begin
            kind_ff       <= kind_in;
            partial_ff    <= partial_in;
            long_count_ff <= long_count_in;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_two_nonzero: assert property (@(posedge clock) disable iff (reset)
      push && push_job.two |-> push_job.second.code_unit != 16'h0000)
      else $error("second result of a word is zero");
   a_long_no_bits: assert property (@(posedge clock) disable iff (reset)
      kind_ff == u2d_pkg::PK_LONG |-> partial_ff == 10'd0)
      else $error("long sequence carries payload bits");
`endif

endmodule
`default_nettype wire

// ===== src/u2d_queue.sv =====
// short job queue between front and back
`default_nettype none
module u2d_queue #(
   parameter int unsigned DEPTH = u2d_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire u2d_pkg::job_type push_job,
   input  wire logic             pop,
   output logic                  full,
   output logic                  head_valid,
   output u2d_pkg::job_type      head_job
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   u2d_pkg::job_type store_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      logic [AW-1:0] r;
      r = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
      return r;
   endfunction

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = store_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== src/u2d_back.sv =====
// result sequencing and output register
`default_nettype none
module u2d_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire u2d_pkg::job_type head_job,
   output logic                  pop,
   u2d_rsp_if.source             rsp
);

   logic                rsp_valid_ff, rsp_valid_in;
   u2d_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                second_ff, second_in;
   logic                load;

   assign load = head_valid && (!rsp_valid_ff || rsp.ready);
   assign pop  = load && (second_ff || !head_job.two);

   assign rsp_data_in  = second_ff ? head_job.second : head_job.first;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
   assign second_in    = load ? !pop : second_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.code_unit   = rsp_data_ff.code_unit;
   assign rsp.is_error    = rsp_data_ff.is_error;
   assign rsp.last_of_run = rsp_data_ff.last_of_run;

`ifndef NO_ASSERTIONS
   a_second_has_head: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> head_valid && head_job.two)
      else $error("second result pending without a two-result job");
   a_word_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.code_unit != 16'h0000)
      else $error("zero code unit delivered");
`endif

endmodule
`default_nettype wire
